>>> design/tcce_pkg.sv
`default_nettype none
package tcce_pkg;
	localparam logic [2:0] FUNC_PUT   = 3'd0;
	localparam logic [2:0] FUNC_CLEAR = 3'd1;
	localparam logic [2:0] FUNC_ATTR  = 3'd2;
	localparam logic [2:0] FUNC_MOVE  = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;

	localparam logic [7:0] CODE_NEWLINE   = 8'd10;
	localparam logic [7:0] CODE_RETURN    = 8'd13;
	localparam logic [7:0] CODE_TAB       = 8'd9;
	localparam logic [7:0] CODE_BACKSPACE = 8'd8;
	localparam logic [7:0] BLANK_CHAR     = 8'h20;
	localparam logic [7:0] ATTR_RESET     = 8'h07;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_PRINT, OP_NEWLINE, OP_RETURN, OP_TAB, OP_BACKSPACE,
		OP_CLEAR, OP_ATTR, OP_MOVE_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       is_read;
		logic       is_move;
		logic [7:0] char_code;
		logic [7:0] attr_value;
		logic [6:0] col;
		logic [5:0] row;
	} cmd_t;
endpackage
`default_nettype wire

>>> design/text_console_character_engine_unit.sv
`default_nettype none
// Character-cell console engine.
// Input channel (in_valid/in_ready) carries one command transaction:
// func, char_code, attr_value, col, row. Each command returns exactly one
// result transaction on the output channel (out_valid/out_ready) with the
// cursor position, its linear index and, for a cell read, the cell bytes.
// Front: accepts and classifies commands into a two-entry queue.
// Back: executes commands against a single-port-write, registered-read
// screen memory of COLUMNS*ROWS cells.
// Cursor moves and printable characters go from acceptance through the
// done state to out_valid; a cell read passes a read state first. Clear
// screen walks all cells, and attribute fill and scroll also sweep them.
// The back end pops the next queued command only once it is idle again,
// after the previous result has been issued.
// Reset clears the cursor to 0,0 and text_attr to 0x07; screen contents
// are undefined until written. When the receiver stalls, hold the result
// and let the queue fill; then drop in_ready.
// cfg_valid/cfg_ready write text_attr; cfg_ready is low while the back works.
module text_console_character_engine_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_STOP = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  attr_value,
	input  wire logic [6:0]  col,
	input  wire logic [4:0]  row,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [7:0]  cfg_data,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [6:0]  cursor_col,
	output      logic [4:0]  cursor_row,
	output      logic [10:0] cursor_index,
	output      logic [7:0]  read_char,
	output      logic [7:0]  read_attr
);
	logic           q_valid, q_pop, busy;
	tcce_pkg::cmd_t q_cmd;
	logic [7:0]     text_attr_q;

	// configuration register: accept writes while the back end is idle
	assign cfg_ready = !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) text_attr_q <= tcce_pkg::ATTR_RESET;
		else if (cfg_valid && cfg_ready) text_attr_q <= cfg_data;
	end

	tcce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .func, .char_code, .attr_value,
		.col, .row, .q_valid, .q_pop, .q_cmd
	);

	tcce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_cmd, .text_attr(text_attr_q), .busy,
		.out_valid, .out_ready, .cursor_col, .cursor_row, .cursor_index,
		.read_char, .read_attr
	);
endmodule
`default_nettype wire

>>> design/tcce_ram.sv
`default_nettype none
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> design/tcce_front.sv
`default_nettype none
module tcce_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	input  wire logic [2:0]     func,
	input  wire logic [7:0]     char_code,
	input  wire logic [7:0]     attr_value,
	input  wire logic [6:0]     col,
	input  wire logic [4:0]     row,
	output      logic           q_valid,
	input  wire logic           q_pop,
	output tcce_pkg::cmd_t      q_cmd
);
	// two-entry queue
	tcce_pkg::cmd_t ent_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	tcce_pkg::cmd_t c;
	logic       push;

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_cmd    = ent_q[rd_q];

	always_comb begin
		c = '0;
		c.char_code  = char_code;
		c.attr_value = attr_value;
		c.col = (col > 7'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : col;
		c.row = (row > 5'(ROWS - 1)) ? 6'(ROWS - 1) : {1'b0, row};
		c.op = tcce_pkg::OP_MOVE_READ;
		unique case (func)
			tcce_pkg::FUNC_PUT: begin
				case (char_code)
					tcce_pkg::CODE_NEWLINE:   c.op = tcce_pkg::OP_NEWLINE;
					tcce_pkg::CODE_RETURN:    c.op = tcce_pkg::OP_RETURN;
					tcce_pkg::CODE_TAB:       c.op = tcce_pkg::OP_TAB;
					tcce_pkg::CODE_BACKSPACE: c.op = tcce_pkg::OP_BACKSPACE;
					default:                  c.op = tcce_pkg::OP_PRINT;
				endcase
			end
			tcce_pkg::FUNC_CLEAR: c.op = tcce_pkg::OP_CLEAR;
			tcce_pkg::FUNC_ATTR:  c.op = tcce_pkg::OP_ATTR;
			tcce_pkg::FUNC_MOVE:  c.is_move = 1'b1;
			tcce_pkg::FUNC_READ:  c.is_read = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) if (push) ent_q[wr_q] <= c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

>>> design/tcce_back.sv
`default_nettype none
module tcce_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_STOP = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output      logic           q_pop,
	input  wire tcce_pkg::cmd_t q_cmd,
	input  wire logic [7:0]     text_attr,
	output      logic           busy,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      logic [6:0]     cursor_col,
	output      logic [4:0]     cursor_row,
	output      logic [10:0]    cursor_index,
	output      logic [7:0]     read_char,
	output      logic [7:0]     read_attr
);
	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int SH = COLUMNS * (ROWS - 1);
	localparam int NSTOPS = (COLUMNS + TAB_STOP - 1) / TAB_STOP;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001, ST_READ = 4'b0010, ST_SWEEP = 4'b0100, ST_DONE = 4'b1000
	} state_t;
	typedef enum logic [1:0] {SW_CLEAR, SW_ATTR, SW_SCROLL} sweep_t;

	state_t state_q;
	sweep_t sw_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] wptr_q;
	logic          wpend_q;
	logic          rend_q;
	logic [7:0]    fattr_q;
	logic [6:0]    ccol_q;
	logic [5:0]    crow_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] rdaddr_q;
	logic          rd_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata, rdata;

	tcce_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	logic       hold;
	logic [7:0] tab_n;
	assign hold = out_valid && !out_ready;
	assign busy = state_q != ST_IDLE;
	assign q_pop = state_q == ST_IDLE && q_valid && !hold;

	// next tab stop: smallest multiple of TAB_STOP beyond the cursor column
	always_comb begin
		tab_n = 8'(NSTOPS * TAB_STOP);
		for (int k = NSTOPS; k >= 1; k--)
			if (8'(k * TAB_STOP) > {1'b0, ccol_q}) tab_n = 8'(k * TAB_STOP);
	end

	// Print write occurs at idle; sweep writes during sweep
	always_comb begin
		we = 1'b0; waddr = base_q + AW'(ccol_q);
		wdata = {text_attr, q_cmd.char_code};
		raddr = rdaddr_q;
		if (state_q == ST_IDLE) begin
			we = q_pop && q_cmd.op == tcce_pkg::OP_PRINT;
			raddr = AW'(q_cmd.row) * AW'(COLUMNS) + AW'(q_cmd.col);
		end else if (state_q == ST_SWEEP) begin
			raddr = ptr_q;
			waddr = wptr_q;
			case (sw_q)
				SW_CLEAR: begin
					we = 1'b1; waddr = ptr_q;
					wdata = {fattr_q, tcce_pkg::BLANK_CHAR};
				end
				SW_ATTR: begin
					we = wpend_q; wdata = {fattr_q, rdata[7:0]};
				end
				default: begin
					if (wpend_q) begin
						we = 1'b1; wdata = rdata;
					end else begin
						we = wptr_q >= AW'(SH);
						wdata = {fattr_q, tcce_pkg::BLANK_CHAR};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; out_valid <= 1'b0;
			ccol_q <= '0; crow_q <= '0; base_q <= '0;
			sw_q <= SW_CLEAR; ptr_q <= '0; wptr_q <= '0; wpend_q <= 1'b0;
			rend_q <= 1'b0; rdaddr_q <= '0;
			fattr_q <= '0; rd_q <= 1'b0;
			cursor_col <= '0; cursor_row <= '0; cursor_index <= '0;
			read_char <= '0; read_attr <= '0;
		end else begin
			if (out_valid && out_ready && state_q != ST_DONE) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (q_pop) begin
					rd_q <= q_cmd.is_read;
					rdaddr_q <= raddr;
					case (q_cmd.op) inside
						tcce_pkg::OP_PRINT, tcce_pkg::OP_NEWLINE, tcce_pkg::OP_TAB: begin
							if (q_cmd.op == tcce_pkg::OP_PRINT && ccol_q != 7'(COLUMNS - 1)) begin
								ccol_q <= ccol_q + 7'd1;
								state_q <= ST_DONE;
							end else if (q_cmd.op == tcce_pkg::OP_TAB
								&& tab_n < 8'(COLUMNS)) begin
								ccol_q <= 7'(tab_n);
								state_q <= ST_DONE;
							end else begin
								ccol_q <= '0;
								if (crow_q == 6'(ROWS - 1)) begin
									state_q <= ST_SWEEP; sw_q <= SW_SCROLL;
									ptr_q <= AW'(COLUMNS); wptr_q <= '0;
									wpend_q <= 1'b0; rend_q <= 1'b0;
									fattr_q <= text_attr;
								end else begin
									crow_q <= crow_q + 6'd1;
									base_q <= base_q + AW'(COLUMNS);
									state_q <= ST_DONE;
								end
							end
						end
						tcce_pkg::OP_RETURN: begin
							ccol_q <= '0;
							state_q <= ST_DONE;
						end
						tcce_pkg::OP_BACKSPACE: begin
							state_q <= ST_DONE;
							if (ccol_q != '0) ccol_q <= ccol_q - 7'd1;
							else if (crow_q != '0) begin
								ccol_q <= 7'(COLUMNS - 1);
								crow_q <= crow_q - 6'd1;
								base_q <= base_q - AW'(COLUMNS);
							end
						end
						tcce_pkg::OP_CLEAR: begin
							ccol_q <= '0; crow_q <= '0; base_q <= '0;
							state_q <= ST_SWEEP; sw_q <= SW_CLEAR;
							ptr_q <= '0; fattr_q <= text_attr;
						end
						tcce_pkg::OP_ATTR: begin
							state_q <= ST_SWEEP; sw_q <= SW_ATTR;
							ptr_q <= '0; wptr_q <= '0; wpend_q <= 1'b0;
							rend_q <= 1'b0;
							fattr_q <= q_cmd.attr_value;
						end
						default: begin
							state_q <= q_cmd.is_read ? ST_READ : ST_DONE;
							if (q_cmd.is_move) begin
								ccol_q <= q_cmd.col; crow_q <= q_cmd.row;
								base_q <= AW'(q_cmd.row) * AW'(COLUMNS);
							end
						end
					endcase
				end
				ST_READ: state_q <= ST_DONE;
				ST_SWEEP: begin
					// read ptr leads write ptr, since the RAM read data is registered
					case (sw_q)
						SW_CLEAR: begin
							ptr_q <= ptr_q + 1'b1;
							if (ptr_q == AW'(CELLS - 1)) state_q <= ST_DONE;
						end
						default: begin
							if (wpend_q) wptr_q <= wptr_q + 1'b1;
							else if (sw_q == SW_SCROLL && wptr_q >= AW'(SH))
								wptr_q <= wptr_q + 1'b1;
							wpend_q <= !rend_q;
							if (!rend_q) begin
								if (ptr_q == AW'(CELLS - 1)) rend_q <= 1'b1;
								else ptr_q <= ptr_q + 1'b1;
							end
							if (wptr_q == AW'(CELLS - 1) && (wpend_q || sw_q == SW_SCROLL))
								state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: if (!hold) begin
					out_valid    <= 1'b1;
					cursor_col   <= ccol_q;
					cursor_row   <= 5'(crow_q);
					cursor_index <= 11'(base_q) + 11'(ccol_q);
					read_char    <= rd_q ? rdata[7:0] : 8'd0;
					read_attr    <= rd_q ? rdata[15:8] : 8'd0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
